/* hdl/lfkx_pkg.sv */
// ----------------------------------------------------------------------------
// lfkx_pkg
// shared types and constants of the filtered shift register byte cipher
// ----------------------------------------------------------------------------
package lfkx_pkg;

    localparam int REG_W          = 91;
    localparam int STEPS_DEFAULT  = 10;
    localparam int BYTE_W         = 8;
    localparam int SEED_W         = 8;
    localparam int SKIP_W         = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;

    localparam logic [SEED_W-1:0] SEED_RESET = 8'd35;
    localparam logic [SKIP_W-1:0] SKIP_RESET = 16'd2048;

    typedef logic [REG_W-1:0] t_ks_reg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED = 1'b0,
        CFG_SKIP = 1'b1
    } t_cfg_idx;

    // one register step: filter bit out, shift right, feedback into the top
    function automatic logic ks_filter(input t_ks_reg r);
        ks_filter = r[1] & (r[REG_W-1] | r[REG_W-3]);
    endfunction

    function automatic t_ks_reg ks_shift(input t_ks_reg r);
        ks_shift = {r[8] ^ r[5] ^ r[1], r[REG_W-1:1]};
    endfunction

endpackage

/* hdl/lfsr_filtered_keystream_xor.sv */
// ----------------------------------------------------------------------------
// lfsr_filtered_keystream_xor
// byte stream cipher from one nonlinearly filtered 91-bit shift register
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries one data byte per item, tuser flags a restart that reloads
//  the seed and clears the byte count before that byte is handled
//  m_axis returns one byte per input item, in order
//  bytes below the skip length pass through, later ones are xored with a
//  keystream byte made by STEPS_PER_BYTE unrolled register steps
//  an item passes the input register, then the result register, with the
//  unrolled step chain between the two; throughput one item per cycle while
//  the receiver takes every result
//  a stalled receiver holds the result register; the input register still
//  takes one more item, after which tready falls until the result is taken
//  reset: seed 35, skip length 2048, byte count zero, register seeded,
//  both stages empty
//  configuration: i_cfg_we with i_cfg_idx 0 (seed) or 1 (skip length),
//  written by the user only while the block is idle, which the block does
//  not enforce itself; a new seed acts at the next restart
// ----------------------------------------------------------------------------
module lfsr_filtered_keystream_xor
    import lfkx_pkg::*;
#(
    parameter int STEPS_PER_BYTE = STEPS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] restart
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BYTE_W-1:0]     m_axis_tdata    // [7:0] out_byte
);

    logic [SEED_W-1:0] r_seed;
    logic [SKIP_W-1:0] r_skip;
    t_ks_reg           r_ks;
    t_ks_reg           n_ks;
    logic [SKIP_W-1:0] r_count;
    logic [SKIP_W-1:0] n_count;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_restart;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic [BYTE_W-1:0] n_out_data;

    logic              w_adv;
    logic              w_take;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        t_ks_reg           v_reg;
        logic [SKIP_W-1:0] v_count;
        logic [BYTE_W-1:0] v_ks;
        v_reg   = r_in_restart ? {{(REG_W-SEED_W){1'b0}}, r_seed} : r_ks;
        v_count = r_in_restart ? '0 : r_count;
        v_ks    = '0;
        if (v_count >= r_skip) begin
            for (int k = 0; k < STEPS_PER_BYTE; k++) begin
                v_ks  = {v_ks[BYTE_W-2:0], ks_filter(v_reg)};
                v_reg = ks_shift(v_reg);
            end
            n_count    = v_count;
            n_out_data = r_in_data ^ v_ks;
        end else begin
            n_count    = v_count + SKIP_W'(1);
            n_out_data = r_in_data;
        end
        n_ks = v_reg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_skip      <= SKIP_RESET;
            r_ks        <= {{(REG_W-SEED_W){1'b0}}, SEED_RESET};
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SEED: r_seed <= i_cfg_data[SEED_W-1:0];
                    CFG_SKIP: r_skip <= i_cfg_data[SKIP_W-1:0];
                    default:  r_skip <= r_skip;
                endcase
            end
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_ks        <= n_ks;
                r_count     <= n_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_data    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser;
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    a_restart_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_restart) |=> (r_count <= SKIP_W'(1)))
        else $error("byte count not cleared by restart");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_restart && (r_count < r_skip))
        |=> (r_count == $past(r_count) + SKIP_W'(1)))
        else $error("byte count did not advance on a passed item");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_restart && (r_count >= r_skip)) |=> $stable(r_count))
        else $error("byte count moved on an encrypted item");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in_restart ? (r_skip != '0) : (r_count < r_skip)))
        |=> (r_out_data == $past(r_in_data)))
        else $error("skipped item was altered");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid || !r_out_valid) |-> s_axis_tready)
        else $error("input stalled with a free stage");
`endif

endmodule

/* test/lfkx_stream_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfkx_stream_check
// watches the cipher's item channels and register writes, keeps its own
// copy of the filtered shift register, byte count and settings, works out
// each expected output byte and compares it with what the block returns
// ----------------------------------------------------------------------------
module lfkx_stream_check
    import lfkx_pkg::*;
#(
    parameter int STEPS_PER_BYTE = STEPS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tuser,   // [0] restart
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
    output int                    o_fail_count,
    output int                    o_pending
);

    t_ks_reg            shift_reg;
    logic [SKIP_W-1:0]  byte_count;
    logic [SKIP_W-1:0]  skip_len;
    logic [SEED_W-1:0]  seed;
    logic [BYTE_W-1:0]  cipher_bytes[$];
    int                 fails = 0;

    task automatic cipher_item(input logic [BYTE_W-1:0] din, input logic restart,
                               output logic [BYTE_W-1:0] dout);
        logic [BYTE_W-1:0] ks;
        logic              filt;
        t_ks_reg           nxt;
        ks = '0;
        if (restart) begin
            shift_reg  = t_ks_reg'(seed);
            byte_count = '0;
        end
        if (byte_count >= skip_len) begin
            for (int k = 0; k < STEPS_PER_BYTE; k++) begin
                filt = shift_reg[1] & (shift_reg[90] | shift_reg[88]);
                ks = {ks[BYTE_W-2:0], filt};
                // feedback taken from the register after the shift
                nxt = shift_reg >> 1;
                nxt[90] = nxt[7] ^ nxt[4] ^ nxt[0];
                shift_reg = nxt;
            end
            dout = din ^ ks;
        end else begin
            byte_count = byte_count + SKIP_W'(1);
            dout = din;
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [BYTE_W-1:0] want;
        logic [BYTE_W-1:0] made;
        if (!i_rst_n) begin
            seed       = SEED_RESET;
            skip_len   = SKIP_RESET;
            byte_count = '0;
            shift_reg  = t_ks_reg'(SEED_RESET);
            cipher_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SEED: begin
                        seed = i_cfg_data[SEED_W-1:0];
                    end
                    CFG_SKIP: begin
                        skip_len = i_cfg_data[SKIP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_bytes.size() == 0) begin
                    $error("out_byte: no item expected, got %02h", m_axis_tdata);
                    fails++;
                end else begin
                    want = cipher_bytes.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("out_byte: expected %02h, got %02h", want, m_axis_tdata);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cipher_item(s_axis_tdata, s_axis_tuser, made);
                cipher_bytes.insert(cipher_bytes.size(), made);
            end
        end
        o_pending    <= cipher_bytes.size();
        o_fail_count <= fails;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// byte stream cipher test: directed items at the edges of the skip length,
// seed and restart, then random phases under changing settings with random
// idling on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module tb;
    import lfkx_pkg::*;

    localparam int STEPS_PER_BYTE = STEPS_DEFAULT;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES    = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;    // [7:0] data_byte
    logic                  s_axis_tuser;    // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BYTE_W-1:0]     m_axis_tdata;    // [7:0] out_byte

    int fail_count;
    int pending;
    int cycles       = 0;
    int stall_left   = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_pending = 1'b0;

    lfsr_filtered_keystream_xor #(
        .STEPS_PER_BYTE(STEPS_PER_BYTE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lfkx_stream_check #(
        .STEPS_PER_BYTE(STEPS_PER_BYTE)
    ) stream_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap(input bit on);
        int r;
        if (!on) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // output side: random stalls, plus the long hold-off when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (rx_idle_on && $urandom_range(99) < 20) begin
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic restart);
        int gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [SEED_W-1:0] seed, input logic [SKIP_W-1:0] skip);
        drain();
        write_reg(CFG_SEED, CFG_DATA_W'(seed));
        write_reg(CFG_SKIP, CFG_DATA_W'(skip));
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int                p;
        int                r;
        logic [SEED_W-1:0] seed_pick;
        logic [SKIP_W-1:0] skip_pick;
        logic [BYTE_W-1:0] data;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SEED;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settings after reset: everything passes through
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        // new seed only counts from the next restart
        reconfigure(8'hFF, 16'd3);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b0);
        // zero skip length, all-zero register
        reconfigure(8'h00, 16'd0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h18, 1'b0);
        send_byte(8'hE7, 1'b0);
        // skip length lowered below the byte count
        reconfigure(8'h80, 16'd5);
        send_byte(8'h11, 1'b1);
        for (int k = 0; k < 4; k++) begin
            send_byte(8'($urandom), 1'b0);
        end
        reconfigure(8'h80, 16'd2);
        for (int k = 0; k < 3; k++) begin
            send_byte(8'($urandom), 1'b0);
        end
        reconfigure(8'hFF, 16'hFFFF);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFE, 1'b0);

        for (p = 0; p < 8; p++) begin
            r = $urandom_range(3);
            seed_pick = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
            r = $urandom_range(9);
            case (r)
                0: skip_pick = 16'd0;
                1: skip_pick = 16'd1;
                2: skip_pick = 16'hFFFF;
                3: skip_pick = 16'($urandom_range(100, 300));
                default: skip_pick = 16'($urandom_range(2, 40));
            endcase
            if (p == 0) begin
                skip_pick = 16'd0;
            end
            reconfigure(seed_pick, skip_pick);
            tx_idle_on = (p != 1);
            rx_idle_on = (p != 1);
            if (p == 3) begin
                // sender keeps offering items while the output is held off
                tx_idle_on   = 1'b0;
                hold_pending = 1'b1;
            end
            for (int k = 0; k < 200; k++) begin
                data = 8'($urandom);
                send_byte(data, (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/lfkx_pkg.sv
hdl/lfsr_filtered_keystream_xor.sv
test/lfkx_stream_check.sv
test/tb.sv
